### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/hduart_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hduart_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TX      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TX_END  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RX      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RX_DONE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RX_ERR  = 3'd5;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_EDGE = 2'd2;

    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] tx_byte;
        logic       rx_level;
    } item_t;

    typedef struct packed {
        logic              rx_error;
        logic              rx_done;
        logic [7:0]        rx_byte;
        logic [MODE_W-1:0] link_state;
        logic              tx_line;
    } res_t;

endpackage

`default_nettype wire

### sv/hduart_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hduart_core #(
    parameter int DATA_BITS = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               step,
    input  hduart_pkg::item_t item,
    input  wire [1:0]         parity_mode,
    output hduart_pkg::res_t  res
);
    import hduart_pkg::*;

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam int CNT_W = $clog2(DATA_BITS + 1);

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]     bit_count_reg, bit_count_next;
    logic                 half_phase_reg, half_phase_next;
    logic                 start_done_reg, start_done_next;
    logic                 rx_start_wait_reg, rx_start_wait_next;
    logic                 parity_flag_reg, parity_flag_next;
    logic                 par_busy_reg, par_busy_next;
    logic                 par_sent_reg, par_sent_next;
    logic                 stop_busy_reg, stop_busy_next;
    logic                 line_reg, line_next;

    logic             par_on;
    logic             hp;
    logic [CNT_W-1:0] cnt_eff;
    logic             do_stop;
    logic             ev;
    logic             par_ok;
    logic             rx_view;

    assign par_on = (parity_mode == PAR_ODD) || (parity_mode == PAR_EVEN);
    assign hp = ~half_phase_reg;
    // first data tick after a send restarts the bit counter
    assign cnt_eff = start_done_reg ? bit_count_reg : '0;
    assign ev = ~^shift_reg;
    assign par_ok = (parity_mode == PAR_EVEN) ? (ev != item.rx_level)
                                              : (ev == item.rx_level);

    always_comb
    begin
        mode_next          = mode_reg;
        shift_next         = shift_reg;
        bit_count_next     = bit_count_reg;
        half_phase_next    = half_phase_reg;
        start_done_next    = start_done_reg;
        rx_start_wait_next = rx_start_wait_reg;
        parity_flag_next   = parity_flag_reg;
        par_busy_next      = par_busy_reg;
        par_sent_next      = par_sent_reg;
        stop_busy_next     = stop_busy_reg;
        line_next          = line_reg;
        do_stop            = 1'b0;

        unique case (item.req_type)
            REQ_TICK:
            begin
                half_phase_next = hp;
                unique case (mode_reg)
                    MODE_TX:
                    begin
                        if (!hp)
                        begin
                            start_done_next = 1'b1;
                            if (cnt_eff < CNT_W'(DATA_BITS))
                            begin
                                line_next      = shift_reg[cnt_eff[IDX_W-1:0]];
                                bit_count_next = cnt_eff + CNT_W'(1);
                            end
                            else
                            begin
                                bit_count_next = cnt_eff;
                                if (!par_on)
                                begin
                                    do_stop = 1'b1;
                                end
                                else if (!par_sent_reg)
                                begin
                                    if (!par_busy_reg)
                                    begin
                                        par_busy_next = 1'b1;
                                        line_next = (parity_mode == PAR_EVEN)
                                                    ? ~parity_flag_reg : parity_flag_reg;
                                    end
                                    else
                                    begin
                                        par_busy_next = 1'b0;
                                        par_sent_next = 1'b1;
                                        do_stop       = 1'b1;
                                    end
                                end
                                else
                                begin
                                    do_stop = 1'b1;
                                end
                                if (do_stop)
                                begin
                                    if (!stop_busy_reg)
                                    begin
                                        stop_busy_next = 1'b1;
                                        line_next      = 1'b1;
                                    end
                                    else
                                    begin
                                        stop_busy_next = 1'b0;
                                        mode_next      = MODE_TX_END;
                                    end
                                end
                            end
                        end
                    end
                    MODE_RX:
                    begin
                        // skip the second half of the start bit
                        if (!(rx_start_wait_reg && hp))
                        begin
                            rx_start_wait_next = 1'b0;
                            if (hp)
                            begin
                                if (bit_count_reg < CNT_W'(DATA_BITS))
                                begin
                                    shift_next[bit_count_reg[IDX_W-1:0]] = item.rx_level;
                                    bit_count_next = bit_count_reg + CNT_W'(1);
                                end
                                else if (par_on && !parity_flag_reg)
                                begin
                                    parity_flag_next = 1'b1;
                                    if (!par_ok)
                                    begin
                                        mode_next = MODE_RX_ERR;
                                    end
                                end
                                else
                                begin
                                    mode_next = item.rx_level ? MODE_RX_DONE : MODE_RX_ERR;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
            REQ_SEND:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    shift_next      = DATA_BITS'(item.tx_byte);
                    start_done_next = 1'b0;
                    par_busy_next   = 1'b0;
                    par_sent_next   = 1'b0;
                    stop_busy_next  = 1'b0;
                    if (par_on)
                    begin
                        parity_flag_next = ~^DATA_BITS'(item.tx_byte);
                    end
                    half_phase_next = 1'b0;
                    line_next       = 1'b0;
                    mode_next       = MODE_TX;
                end
            end
            REQ_EDGE:
            begin
                if (mode_reg != MODE_RX && mode_reg != MODE_RX_DONE
                    && mode_reg != MODE_RX_ERR)
                begin
                    rx_start_wait_next = 1'b1;
                    half_phase_next    = 1'b0;
                    bit_count_next     = '0;
                    shift_next         = '0;
                    parity_flag_next   = 1'b0;
                    stop_busy_next     = 1'b0;
                    par_busy_next      = 1'b0;
                    par_sent_next      = 1'b0;
                    line_next          = 1'b1;
                    mode_next          = MODE_RX;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rx_view = (mode_next == MODE_RX) || (mode_next == MODE_RX_DONE)
                     || (mode_next == MODE_RX_ERR);

    always_comb
    begin
        res.tx_line    = line_next;
        res.link_state = mode_next;
        res.rx_byte    = rx_view ? 8'(shift_next) : 8'd0;
        res.rx_done    = (mode_next == MODE_RX_DONE);
        res.rx_error   = (mode_next == MODE_RX_ERR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            shift_reg         <= '0;
            bit_count_reg     <= '0;
            half_phase_reg    <= 1'b0;
            start_done_reg    <= 1'b0;
            rx_start_wait_reg <= 1'b0;
            parity_flag_reg   <= 1'b0;
            par_busy_reg      <= 1'b0;
            par_sent_reg      <= 1'b0;
            stop_busy_reg     <= 1'b0;
            line_reg          <= 1'b1;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            shift_reg         <= shift_next;
            bit_count_reg     <= bit_count_next;
            half_phase_reg    <= half_phase_next;
            start_done_reg    <= start_done_next;
            rx_start_wait_reg <= rx_start_wait_next;
            parity_flag_reg   <= parity_flag_next;
            par_busy_reg      <= par_busy_next;
            par_sent_reg      <= par_sent_next;
            stop_busy_reg     <= stop_busy_next;
            line_reg          <= line_next;
        end
    end

endmodule

`default_nettype wire

### sv/half_duplex_uart_with_parity_top.sv
// Half-duplex UART with optional parity, event driven.
// Input stream (s_axis): one beat per event. tuser = req_type (0 tick at twice
// the bit rate, 1 send byte, 2 receive line falling edge). tdata[7:0] = byte to
// send, tdata[8] = receive line level sampled with the tick.
// Output stream (m_axis): exactly one beat per input beat, showing the state
// after that event: tx_line, link_state, rx_byte, rx_done, rx_error.
// Config channel (cfg_*): parity mode, 0 none, 1 odd, 2 even (3 acts as none);
// write only while the stream is quiet. cfg_ready is always high.
// Pipeline: an accepted beat waits in the input register; the core processes it
// when the output register is empty or being taken, and the result is presented
// on m_axis from the output register.
// Throughput: one beat per cycle while m_axis_tready stays high; the single
// state update between input and output register is the only per-event work.
// Reset: asynchronous, active low; link idle, tx_line high, parity none,
// both stream registers empty.
// Stall: while m_axis_tready is low the output register holds its beat; one
// more beat can still be taken into the input register, then s_axis_tready
// drops until the output side drains.
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_uart_with_parity_top #(
    parameter int DATA_BITS = 8
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [15:0] s_axis_tdata,   // tx_byte[7:0], rx_level[8], zero pad
    input  wire [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // tx_line[0], link_state[3:1],
                                       // rx_byte[11:4], rx_done[12],
                                       // rx_error[13], zero pad
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_data
);
    import hduart_pkg::*;

    logic       in_vld_reg;
    item_t      in_item_reg;
    logic       out_vld_reg;
    res_t       out_res_reg;
    logic [1:0] parity_mode_reg;
    logic       adv;
    res_t       core_res;

    assign adv           = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || adv;
    assign cfg_ready     = 1'b1;

    hduart_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .item        (in_item_reg),
        .parity_mode (parity_mode_reg),
        .res         (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            parity_mode_reg <= 2'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                parity_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.req_type <= s_axis_tuser;
            in_item_reg.tx_byte  <= s_axis_tdata[7:0];
            in_item_reg.rx_level <= s_axis_tdata[8];
        end
        if (adv)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg};

endmodule

`default_nettype wire

### sv/hduart_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hduart_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    import hduart_pkg::*;

    logic              tx_line;
    logic [MODE_W-1:0] link_state;
    logic [7:0]        rx_byte;
    logic              rx_done;
    logic              rx_error;
    logic              rx_side;
    logic              stalled;
    logic              flags_match;
    logic              line_rests;

    assign tx_line    = m_axis_tdata[0];
    assign link_state = m_axis_tdata[3:1];
    assign rx_byte    = m_axis_tdata[11:4];
    assign rx_done    = m_axis_tdata[12];
    assign rx_error   = m_axis_tdata[13];
    assign rx_side    = (link_state == MODE_RX) || (link_state == MODE_RX_DONE)
                        || (link_state == MODE_RX_ERR);
    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign flags_match = (rx_done == (link_state == MODE_RX_DONE))
                         && (rx_error == (link_state == MODE_RX_ERR));
    assign line_rests  = (link_state == MODE_IDLE) || rx_side;

    // a stalled beat must not change
    `ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMPLY(a_done_flag, clk, rst_n, m_axis_tvalid, flags_match)
    // line rests high when idle or on the receive side
    `ASSERT_IMPLY(a_line_idle, clk, rst_n, m_axis_tvalid && line_rests, tx_line)
    `ASSERT_IMPLY(a_rx_byte_zero, clk, rst_n, m_axis_tvalid && !rx_side, rx_byte == 8'd0)

endmodule

bind half_duplex_uart_with_parity_top hduart_checker u_hduart_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/hduart_link_checker.sv
`timescale 1ns / 1ps

module hduart_link_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    input  wire        s_axis_tready,
    input  wire [15:0] s_axis_tdata,   // tx_byte[7:0], rx_level[8], zero pad
    input  wire [1:0]  s_axis_tuser,   // req_type[1:0]
    input  wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    input  wire [15:0] m_axis_tdata,   // tx_line[0], link_state[3:1], rx_byte[11:4],
                                       // rx_done[12], rx_error[13], zero pad
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire [1:0]  cfg_data,
    output int         mismatch_count,
    output int         status_pending
);
    import hduart_pkg::*;

    localparam int DATA_BITS = 8;

    // model of the link, updated once per accepted input beat
    logic [1:0]        par_mode;
    logic [MODE_W-1:0] st_mode;
    logic [7:0]        st_shift;
    logic [3:0]        st_bits;
    logic              st_half;
    logic              st_start_done;
    logic              st_rx_wait;
    logic              st_par_flag;
    logic              st_par_busy;
    logic              st_par_sent;
    logic              st_stop_busy;
    logic              st_line;

    res_t link_status_q[$];

    initial
    begin
        mismatch_count = 0;
        status_pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic logic parity_enabled();
        return par_mode == PAR_ODD || par_mode == PAR_EVEN;
    endfunction

    task automatic stop_bit_phase();
        if (!st_stop_busy)
        begin
            st_stop_busy = 1'b1;
            st_line = 1'b1;
        end
        else
        begin
            st_stop_busy = 1'b0;
            st_mode = MODE_TX_END;
        end
    endtask

    // transmitter only moves on ticks that bring the half phase back to 0
    task automatic tx_tick();
        if (st_half == 1'b0)
        begin
            if (!st_start_done)
            begin
                st_start_done = 1'b1;
                st_bits = '0;
            end
            if (st_bits < DATA_BITS)
            begin
                st_line = st_shift[st_bits[2:0]];
                st_bits = st_bits + 4'd1;
            end
            else if (!parity_enabled())
                stop_bit_phase();
            else if (!st_par_sent && !st_par_busy)
            begin
                st_par_busy = 1'b1;
                // par flag = data has an even number of ones
                st_line = (par_mode == PAR_EVEN) ? !st_par_flag : st_par_flag;
            end
            else
            begin
                if (!st_par_sent)
                begin
                    st_par_busy = 1'b0;
                    st_par_sent = 1'b1;
                end
                stop_bit_phase();
            end
        end
    endtask

    task automatic rx_tick(input logic level);
        logic even_ones;
        logic good;
        // first odd tick after the edge is still the start bit
        if (!(st_rx_wait && st_half))
        begin
            st_rx_wait = 1'b0;
            if (st_half)
            begin
                if (st_bits < DATA_BITS)
                begin
                    st_shift[st_bits[2:0]] = level;
                    st_bits = st_bits + 4'd1;
                end
                else if (parity_enabled() && !st_par_flag)
                begin
                    even_ones = ~^st_shift;
                    good = (par_mode == PAR_EVEN) ? (even_ones != level) : (even_ones == level);
                    st_par_flag = 1'b1;
                    if (!good)
                        st_mode = MODE_RX_ERR;
                end
                else
                    st_mode = level ? MODE_RX_DONE : MODE_RX_ERR;
            end
        end
    endtask

    function automatic logic in_rx_view();
        return st_mode == MODE_RX || st_mode == MODE_RX_DONE || st_mode == MODE_RX_ERR;
    endfunction

    task automatic advance_link(input item_t ev, output res_t status);
        case (ev.req_type)
            REQ_TICK:
            begin
                st_half = ~st_half;
                case (st_mode)
                    MODE_TX: tx_tick();
                    MODE_RX: rx_tick(ev.rx_level);
                    default: st_mode = MODE_IDLE;
                endcase
            end
            REQ_SEND:
            begin
                if (st_mode == MODE_IDLE)
                begin
                    st_shift = ev.tx_byte;
                    st_start_done = 1'b0;
                    st_par_busy = 1'b0;
                    st_par_sent = 1'b0;
                    st_stop_busy = 1'b0;
                    if (parity_enabled())
                        st_par_flag = ~^ev.tx_byte;
                    st_half = 1'b0;
                    st_line = 1'b0;
                    st_mode = MODE_TX;
                end
            end
            REQ_EDGE:
            begin
                // also drops a frame that is being sent
                if (!in_rx_view())
                begin
                    st_rx_wait = 1'b1;
                    st_half = 1'b0;
                    st_bits = '0;
                    st_shift = '0;
                    st_par_flag = 1'b0;
                    st_stop_busy = 1'b0;
                    st_par_busy = 1'b0;
                    st_par_sent = 1'b0;
                    st_line = 1'b1;
                    st_mode = MODE_RX;
                end
            end
            default: ;
        endcase
        status.tx_line    = st_line;
        status.link_state = st_mode;
        status.rx_byte    = in_rx_view() ? st_shift : 8'd0;
        status.rx_done    = st_mode == MODE_RX_DONE;
        status.rx_error   = st_mode == MODE_RX_ERR;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t ev;
        res_t  status;
        res_t  got;
        res_t  want;
        if (!rst_n)
        begin
            par_mode = 2'd0;
            st_mode = MODE_IDLE;
            st_shift = '0;
            st_bits = '0;
            st_half = 1'b0;
            st_start_done = 1'b0;
            st_rx_wait = 1'b0;
            st_par_flag = 1'b0;
            st_par_busy = 1'b0;
            st_par_sent = 1'b0;
            st_stop_busy = 1'b0;
            st_line = 1'b1;
            link_status_q.delete();
            status_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                par_mode = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                ev.req_type = s_axis_tuser;
                ev.tx_byte  = s_axis_tdata[7:0];
                ev.rx_level = s_axis_tdata[8];
                advance_link(ev, status);
                link_status_q.push_back(status);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata[13:0]);
                if (link_status_q.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                else
                begin
                    want = link_status_q.pop_front();
                    if (got.tx_line !== want.tx_line)
                        report_mismatch("tx_line", got.tx_line, want.tx_line);
                    if (got.link_state !== want.link_state)
                        report_mismatch("link_state", got.link_state, want.link_state);
                    if (got.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                    if (got.rx_done !== want.rx_done)
                        report_mismatch("rx_done", got.rx_done, want.rx_done);
                    if (got.rx_error !== want.rx_error)
                        report_mismatch("rx_error", got.rx_error, want.rx_error);
                end
            end

            status_pending = link_status_q.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hduart_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_EVENTS = 250;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [1:0] PAR_NONE    = 2'd0;
    localparam logic [1:0] PAR_UNUSED  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;    // tx_byte[7:0], rx_level[8], zero pad
    logic [1:0]  s_axis_tuser = '0;    // req_type[1:0]
    logic        m_axis_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;         // tx_line[0], link_state[3:1], rx_byte[11:4],
                                       // rx_done[12], rx_error[13], zero pad
    wire         cfg_ready;

    int         mismatch_count;
    int         status_pending;
    int         sender_idle_pct = 0;
    int         receiver_idle_pct = 0;
    int         cycles = 0;
    int         events_sent = 0;
    logic [1:0] parity_sel = PAR_NONE;

    half_duplex_uart_with_parity_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    hduart_link_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .status_pending (status_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_send_or_edge();
        return $urandom_range(1) ? REQ_SEND : REQ_EDGE;
    endfunction

    task automatic push_event(input logic [1:0] kind, input logic [7:0] data, input logic level);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, level, data};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sent++;
    endtask

    // hold off the sender until every status beat is back
    task automatic drain_link();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (status_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_parity(input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        parity_sel = value;
    endtask

    // line levels of a whole frame, fed one bit per odd tick from tick 3 on
    task automatic rx_frame();
        logic [9:0] frame;
        logic [7:0] data;
        int nbits;
        int n_ticks;
        int idx;
        data = pick_byte();
        frame = '0;
        frame[7:0] = data;
        nbits = 9;
        if (parity_sel == PAR_ODD || parity_sel == PAR_EVEN)
        begin
            frame[8] = (parity_sel == PAR_ODD) ? ~^data : ^data;
            if ($urandom_range(7) == 0)
                frame[8] = ~frame[8];
            nbits = 10;
        end
        frame[nbits-1] = ($urandom_range(7) != 0);
        push_event(REQ_EDGE, 8'($urandom), 1'($urandom));
        n_ticks = 2 * nbits + 2 + $urandom_range(2);
        for (int t = 1; t <= n_ticks; t++)
        begin
            if ($urandom_range(15) == 0)
                push_event(pick_send_or_edge(), pick_byte(), 1'($urandom));
            idx = (t - 3) / 2;
            if (t >= 3 && (t % 2) == 1 && idx < nbits)
                push_event(REQ_TICK, 8'($urandom), frame[idx]);
            else
                push_event(REQ_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic tx_frame();
        int nbits;
        int n_ticks;
        nbits = (parity_sel == PAR_ODD || parity_sel == PAR_EVEN) ? 11 : 10;
        push_event(REQ_SEND, pick_byte(), 1'($urandom));
        n_ticks = 2 * nbits + 1 + $urandom_range(2);
        repeat (n_ticks)
        begin
            if ($urandom_range(19) == 0)
                push_event(pick_send_or_edge(), pick_byte(), 1'($urandom));
            push_event(REQ_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_phase(input logic [1:0] parity, input int tx_pct, input int rx_pct);
        int goal;
        int midpoint;
        int pick;
        bit drained;
        drain_link();
        write_parity(parity);
        sender_idle_pct = tx_pct;
        receiver_idle_pct = rx_pct;
        goal = events_sent + PHASE_EVENTS;
        midpoint = events_sent + PHASE_EVENTS / 2;
        drained = 1'b0;
        while (events_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                rx_frame();
            else if (pick < 75)
                tx_frame();
            else
                repeat ($urandom_range(1, 6))
                    push_event(2'($urandom), 8'($urandom), 1'($urandom));
            if (!drained && events_sent >= midpoint)
            begin
                drained = 1'b1;
                drain_link();
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown request, idle ticks, busy send, edge during transmit,
        // ignored edge and send while receiving, then a partial receive
        push_event(REQ_UNKNOWN, 8'hFF, 1'b1);
        push_event(REQ_TICK, 8'h00, 1'b0);
        push_event(REQ_TICK, 8'hFF, 1'b1);
        push_event(REQ_SEND, 8'hFF, 1'b1);
        push_event(REQ_SEND, 8'h00, 1'b0);
        push_event(REQ_TICK, 8'h00, 1'b0);
        push_event(REQ_TICK, 8'h00, 1'b1);
        push_event(REQ_EDGE, 8'h80, 1'b0);
        push_event(REQ_EDGE, 8'h01, 1'b1);
        push_event(REQ_SEND, 8'hA5, 1'b0);
        push_event(REQ_TICK, 8'h00, 1'b1);
        push_event(REQ_TICK, 8'h00, 1'b0);
        for (int t = 0; t < 10; t++)
            push_event(REQ_TICK, 8'hFF, t[1] ^ t[0]);

        run_phase(PAR_ODD, 32, 81);
        run_phase(PAR_EVEN, 32, 81);
        run_phase(PAR_NONE, 81, 32);
        run_phase(PAR_UNUSED, 81, 32);
        run_phase(PAR_EVEN, 0, 0);
        run_phase(PAR_ODD, 0, 0);

        drain_link();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/hduart_pkg.sv
sv/hduart_core.sv
sv/half_duplex_uart_with_parity_top.sv
sv/hduart_checker.sv
bench/hduart_link_checker.sv
bench/tb_top.sv
